// File: sv/cse_pkg.sv
`default_nettype none
package cse_pkg;

  // Memory address width (8..16); the program counter stays 16 bits.
  localparam int ADDR_WIDTH = 16;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_EXEC  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_SETPC = 2'd3;

  localparam logic [7:0] OP_DAA  = 8'h27;
  localparam logic [7:0] OP_HLT  = 8'h76;
  localparam logic [7:0] OP_SHLD = 8'h22;
  localparam logic [7:0] OP_LHLD = 8'h2a;

  // register codes
  localparam logic [2:0] RC_B = 3'd0;
  localparam logic [2:0] RC_C = 3'd1;
  localparam logic [2:0] RC_D = 3'd2;
  localparam logic [2:0] RC_E = 3'd3;
  localparam logic [2:0] RC_H = 3'd4;
  localparam logic [2:0] RC_L = 3'd5;
  localparam logic [2:0] RC_M = 3'd6;
  localparam logic [2:0] RC_A = 3'd7;

  // pair codes
  localparam logic [1:0] RP_BC = 2'd0;
  localparam logic [1:0] RP_DE = 2'd1;
  localparam logic [1:0] RP_HL = 2'd2;
  localparam logic [1:0] RP_SP = 2'd3;

  // flag bit positions
  localparam int F_S = 3;
  localparam int F_Z = 2;
  localparam int F_P = 1;
  localparam int F_C = 0;

  typedef enum logic [3:0] {
    S_IDLE, S_WRMEM, S_RDREQ, S_RDCAP, S_SETPC,
    S_OPREQ, S_OPCAP, S_DECODE, S_B1REQ, S_B1CAP, S_B2REQ, S_B2CAP,
    S_DREQ, S_DCAP, S_D2REQ, S_D2CAP
  } state_t;

  typedef enum logic [2:0] {
    MA_ITEM, MA_PC, MA_PC1, MA_PC2, MA_DATA, MA_DATA1
  } mem_sel_t;

  typedef enum logic [1:0] {
    WD_ITEM, WD_EXEC, WD_HIGH
  } wr_sel_t;

  typedef struct packed {
    logic     latch_item;
    mem_sel_t mem_sel;
    logic     mem_rd;
    logic     mem_wr;
    wr_sel_t  wr_sel;
    logic     cap_rd;
    logic     cap_op;
    logic     cap_b1;
    logic     cap_b2;
    logic     cap_t1;
    logic     cap_t2;
    logic     set_fault;
    logic     exec;
    logic     set_pc;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       fault;
    logic [1:0] len;
    logic       need_rd;
    logic       need_rd2;
    logic       need_wr;
    logic       need_wr2;
  } status_t;

endpackage
`default_nettype wire

// File: sv/cse_if.sv
`default_nettype none
interface cse_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] address;
  logic [7:0]  data;
  modport source (output valid, kind, address, data, input ready);
  modport sink   (input valid, kind, address, data, output ready);
endinterface

interface cse_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_pc;
  logic [15:0] out_sp;
  logic [7:0]  out_a;
  logic [7:0]  out_b;
  logic [7:0]  out_c;
  logic [7:0]  out_d;
  logic [7:0]  out_e;
  logic [7:0]  out_h;
  logic [7:0]  out_l;
  logic [3:0]  out_flags;
  logic [7:0]  read_byte;
  logic        fault;
  modport source (output valid, out_pc, out_sp, out_a, out_b, out_c, out_d, out_e,
                  out_h, out_l, out_flags, read_byte, fault, input ready);
  modport sink   (input valid, out_pc, out_sp, out_a, out_b, out_c, out_d, out_e,
                  out_h, out_l, out_flags, read_byte, fault, output ready);
endinterface
`default_nettype wire

// File: sv/cpu8080_subset_execute.sv
`default_nettype none
// Channel | Dir | Payload                                   | Beat
// req     | in  | kind, address, data                       | valid & ready
// rsp     | out | out_pc..out_l, out_flags, read_byte, fault | valid & ready
//
// One item at a time. Memory write: S_WRMEM; set pc: S_SETPC; memory read: S_RDREQ, S_RDCAP.
// Execute: S_OPREQ, S_OPCAP and S_DECODE for a one-byte opcode, plus a request and a capture
// state per operand byte and per data read through the single memory port; SHLD adds one write.
// Reset (rst, synchronous) clears pc, sp, A..L and flags; memory is left as is.
// A full result register holds the last step until rsp is taken.
module cpu8080_subset_execute (
  input wire logic clk,
  input wire logic rst,
  cse_in_if.sink   req,
  cse_out_if.source rsp
);
  import cse_pkg::*;

  cmd_t    cmd;
  status_t st;

  cse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  cse_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_kind    (req.kind),
    .in_address (req.address),
    .in_data    (req.data),
    .out_pc     (rsp.out_pc),
    .out_sp     (rsp.out_sp),
    .out_a      (rsp.out_a),
    .out_b      (rsp.out_b),
    .out_c      (rsp.out_c),
    .out_d      (rsp.out_d),
    .out_e      (rsp.out_e),
    .out_h      (rsp.out_h),
    .out_l      (rsp.out_l),
    .out_flags  (rsp.out_flags),
    .read_byte  (rsp.read_byte),
    .fault      (rsp.fault)
  );

endmodule
`default_nettype wire

// File: sv/cse_ctrl.sv
`default_nettype none
module cse_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire cse_pkg::status_t st,
  output cse_pkg::cmd_t         cmd
);
  import cse_pkg::*;

  state_t state, state_next;
  logic   exec_go;   // last fetch done: execute and finish this beat
  logic   finish;    // result ready to load
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // states that end an item wait here until the output register is free
  always_comb begin
    exec_go = 1'b0;
    finish  = 1'b0;
    unique case (state)
      S_WRMEM, S_RDCAP, S_SETPC: finish = 1'b1;
      S_DECODE: begin
        finish  = st.fault || (st.len == 2'd1 && !st.need_rd);
        exec_go = !st.fault && st.len == 2'd1 && !st.need_rd;
      end
      S_B1CAP: begin
        finish  = (st.len == 2'd2) && !st.need_rd;
        exec_go = finish;
      end
      S_B2CAP: begin
        finish  = !st.need_rd;
        exec_go = finish;
      end
      S_DCAP: begin
        finish  = !st.need_rd2;
        exec_go = finish;
      end
      S_D2CAP: begin
        finish  = 1'b1;
        exec_go = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) begin
        unique case (st.kind)
          KIND_WRITE: state_next = S_WRMEM;
          KIND_READ:  state_next = S_RDREQ;
          KIND_SETPC: state_next = S_SETPC;
          default:    state_next = S_OPREQ;
        endcase
      end
      S_RDREQ: state_next = S_RDCAP;
      S_OPREQ: state_next = S_OPCAP;
      S_OPCAP: state_next = S_DECODE;
      S_DECODE: begin
        if (finish) begin
          if (out_free && !st.need_wr2) state_next = S_IDLE;
        end else if (st.len != 2'd1) state_next = S_B1REQ;
        else state_next = S_DREQ;
      end
      S_B1REQ: state_next = S_B1CAP;
      S_B1CAP: begin
        if (finish) begin
          if (out_free) state_next = S_IDLE;
        end else if (st.len == 2'd3) state_next = S_B2REQ;
        else state_next = S_DREQ;
      end
      S_B2REQ: state_next = S_B2CAP;
      S_B2CAP: begin
        if (finish) begin
          if (out_free && !st.need_wr2) state_next = S_IDLE;
        end else state_next = S_DREQ;
      end
      S_DREQ: state_next = S_DCAP;
      S_DCAP: begin
        if (finish) begin
          if (out_free) state_next = S_IDLE;
        end else state_next = S_D2REQ;
      end
      S_D2REQ: state_next = S_D2CAP;
      S_D2CAP, S_WRMEM, S_RDCAP, S_SETPC: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // SHLD second byte: written in the same wait slot after execute; we
  // handle it by holding in B2CAP with exec done once (see wr2_done).
  logic wr2_done;

  always_comb begin
    cmd = '0;
    cmd.mem_sel = MA_ITEM;
    cmd.wr_sel  = WD_ITEM;
    unique case (state)
      S_IDLE:  cmd.latch_item = in_valid;
      S_WRMEM: begin
        cmd.mem_wr   = out_free;
        cmd.load_out = out_free;
      end
      S_RDREQ: cmd.mem_rd = 1'b1;
      S_RDCAP: begin
        cmd.cap_rd   = 1'b1;
        cmd.load_out = out_free;
      end
      S_SETPC: begin
        cmd.set_pc   = out_free;
        cmd.load_out = out_free;
      end
      S_OPREQ: begin
        cmd.mem_sel = MA_PC;
        cmd.mem_rd  = 1'b1;
      end
      S_OPCAP: cmd.cap_op = 1'b1;
      S_B1REQ: begin
        cmd.mem_sel = MA_PC1;
        cmd.mem_rd  = 1'b1;
      end
      S_B2REQ: begin
        cmd.mem_sel = MA_PC2;
        cmd.mem_rd  = 1'b1;
      end
      S_DREQ: begin
        cmd.mem_sel = MA_DATA;
        cmd.mem_rd  = 1'b1;
      end
      S_D2REQ: begin
        cmd.mem_sel = MA_DATA1;
        cmd.mem_rd  = 1'b1;
      end
      default: ;
    endcase
    unique case (state)
      S_B1CAP: cmd.cap_b1 = 1'b1;
      S_B2CAP: cmd.cap_b2 = !wr2_done;
      S_DCAP:  cmd.cap_t1 = 1'b1;
      S_D2CAP: cmd.cap_t2 = 1'b1;
      default: ;
    endcase
    if (state == S_DECODE && st.fault) begin
      cmd.set_fault = 1'b1;
      cmd.load_out  = out_free;
    end
    if (exec_go) begin
      if (st.need_wr2 && !wr2_done) begin
        // SHLD: execute writes L, a later pass writes H once the output is free, then finishes
        cmd.exec    = 1'b1;
        cmd.mem_wr  = 1'b1;
        cmd.mem_sel = MA_DATA;
        cmd.wr_sel  = WD_EXEC;
      end else if (st.need_wr2) begin
        cmd.mem_wr   = out_free;
        cmd.mem_sel  = MA_DATA1;
        cmd.wr_sel   = WD_HIGH;
        cmd.load_out = out_free;
      end else begin
        cmd.exec     = out_free;
        cmd.mem_wr   = out_free && st.need_wr;
        cmd.mem_sel  = MA_DATA;
        cmd.wr_sel   = WD_EXEC;
        cmd.load_out = out_free;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      wr2_done  <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        state <= S_IDLE;
        wr2_done <= 1'b0;
      end else begin
        state <= state_next;
        if (cmd.exec && st.need_wr2) wr2_done <= 1'b1;
      end
      if (cmd.load_out)   out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_rd_wr_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_rd && cmd.mem_wr)) else $error("memory read and write together");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state != S_IDLE) else $error("accept did not start work");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready)) else $error("result overwritten");
  a_no_exec_fault: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !st.fault) else $error("faulted opcode executed");
  a_exec_once: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> !cmd.exec) else $error("instruction executed twice");

endmodule
`default_nettype wire

// File: sv/cse_dpath.sv
`default_nettype none
module cse_dpath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cse_pkg::cmd_t   cmd,
  output cse_pkg::status_t     st,
  input  wire logic [1:0]      in_kind,
  input  wire logic [15:0]     in_address,
  input  wire logic [7:0]      in_data,
  output logic [15:0]          out_pc,
  output logic [15:0]          out_sp,
  output logic [7:0]           out_a,
  output logic [7:0]           out_b,
  output logic [7:0]           out_c,
  output logic [7:0]           out_d,
  output logic [7:0]           out_e,
  output logic [7:0]           out_h,
  output logic [7:0]           out_l,
  output logic [3:0]           out_flags,
  output logic [7:0]           read_byte,
  output logic                 fault
);
  import cse_pkg::*;

  logic [7:0] mem [2**ADDR_WIDTH];
  logic [7:0] mem_q;

  logic [15:0] item_addr;
  logic [7:0]  item_data;
  logic [15:0] pc, sp;
  logic [7:0]  ra, rb, rc, rd, re, rh, rl;
  logic [3:0]  flags;
  logic [7:0]  op, b1, b2, t1, t2, rbyte;
  logic        flt;
  logic [7:0]  b1_v, b2_v, t1_v, t2_v;

  logic [15:0] imm16, hl, rp_val, daddr, maddr16;
  logic [ADDR_WIDTH-1:0] maddr;
  logic [7:0]  src_val, dst_val, wdata_x, wdata, v;
  logic [16:0] sum;
  logic        rw_en, pw_en;
  logic [2:0]  rw_code;
  logic [7:0]  rw_val;
  logic [1:0]  pw_code;
  logic [15:0] pw_val;
  logic [3:0]  flags_n;

  // fetched bytes are usable in the cycle that captures them
  assign b1_v = cmd.cap_b1 ? mem_q : b1;
  assign b2_v = cmd.cap_b2 ? mem_q : b2;
  assign t1_v = cmd.cap_t1 ? mem_q : t1;
  assign t2_v = cmd.cap_t2 ? mem_q : t2;

  assign imm16 = {b2_v, b1_v};
  assign hl    = {rh, rl};

  function automatic logic [7:0] pick(input logic [2:0] code, input logic [7:0] b,
      input logic [7:0] c, input logic [7:0] d, input logic [7:0] e,
      input logic [7:0] h, input logic [7:0] l, input logic [7:0] m,
      input logic [7:0] a);
    logic [7:0] r;
    unique case (code)
      RC_B: r = b;
      RC_C: r = c;
      RC_D: r = d;
      RC_E: r = e;
      RC_H: r = h;
      RC_L: r = l;
      RC_M: r = m;
      default: r = a;
    endcase
    return r;
  endfunction

  assign src_val = pick(op[2:0], rb, rc, rd, re, rh, rl, t1_v, ra);
  assign dst_val = pick(op[5:3], rb, rc, rd, re, rh, rl, t1_v, ra);

  always_comb begin
    unique case (op[5:4])
      RP_BC: rp_val = {rb, rc};
      RP_DE: rp_val = {rd, re};
      RP_HL: rp_val = hl;
      default: rp_val = sp;
    endcase
  end

  assign daddr = (op[7:6] == 2'b00 && op[2:0] == 3'd2) ? (op[5] ? imm16 : rp_val) : hl;

  // decode
  always_comb begin
    st.kind     = in_kind;
    st.fault    = op[7] || op == OP_DAA || op == OP_HLT;
    st.len      = 2'd1;
    st.need_rd  = 1'b0;
    st.need_wr  = 1'b0;
    st.need_rd2 = (op == OP_LHLD);
    st.need_wr2 = (op == OP_SHLD);
    if (op[7:6] == 2'b01) begin
      st.need_rd = (op[2:0] == RC_M);
      st.need_wr = (op[5:3] == RC_M);
    end else if (op[7:6] == 2'b00) begin
      unique case (op[2:0])
        3'd1: if (!op[3]) st.len = 2'd3;
        3'd2: begin
          if (op[5]) st.len = 2'd3;
          st.need_rd = op[3];
          st.need_wr = !op[3] && (op != OP_SHLD);
        end
        3'd4, 3'd5: begin
          st.need_rd = (op[5:3] == RC_M);
          st.need_wr = (op[5:3] == RC_M);
        end
        3'd6: begin
          st.len     = 2'd2;
          st.need_wr = (op[5:3] == RC_M);
        end
        default: ;
      endcase
    end
  end

  // execute
  always_comb begin
    rw_en   = 1'b0;
    rw_code = op[5:3];
    rw_val  = src_val;
    pw_en   = 1'b0;
    pw_code = op[5:4];
    pw_val  = imm16;
    flags_n = flags;
    wdata_x = src_val;
    sum     = {1'b0, hl} + {1'b0, rp_val};
    v       = op[0] ? dst_val - 8'd1 : dst_val + 8'd1;
    if (op[7:6] == 2'b01) begin
      rw_en = 1'b1;
    end else begin
      case (op[2:0])
        3'd1: begin
          pw_en = 1'b1;
          if (op[3]) begin
            pw_code      = RP_HL;
            pw_val       = sum[15:0];
            flags_n[F_C] = sum[16];
          end
        end
        3'd2: begin
          wdata_x = (op[5:3] == 3'd4) ? rl : ra;
          if (op == OP_LHLD) begin
            pw_en   = 1'b1;
            pw_code = RP_HL;
            pw_val  = {t2_v, t1_v};
          end else if (op[3]) begin
            rw_en   = 1'b1;
            rw_code = RC_A;
            rw_val  = t1_v;
          end
        end
        3'd3: begin
          pw_en  = 1'b1;
          pw_val = op[3] ? rp_val - 16'd1 : rp_val + 16'd1;
        end
        3'd4, 3'd5: begin
          rw_en   = 1'b1;
          rw_val  = v;
          wdata_x = v;
          flags_n = {v[7], v == 8'd0, ~^v, flags[F_C]};
        end
        3'd6: begin
          rw_en   = 1'b1;
          rw_val  = b1_v;
          wdata_x = b1_v;
        end
        3'd7: begin
          rw_code = RC_A;
          case (op[5:3])
            3'd0: begin
              rw_en = 1'b1; rw_val = {ra[6:0], ra[7]}; flags_n[F_C] = ra[7];
            end
            3'd1: begin
              rw_en = 1'b1; rw_val = {ra[0], ra[7:1]}; flags_n[F_C] = ra[0];
            end
            3'd2: begin
              rw_en = 1'b1; rw_val = {ra[6:0], flags[F_C]}; flags_n[F_C] = ra[7];
            end
            3'd3: begin
              rw_en = 1'b1; rw_val = {flags[F_C], ra[7:1]}; flags_n[F_C] = ra[0];
            end
            3'd5: begin
              rw_en = 1'b1; rw_val = ~ra;
            end
            3'd6: flags_n[F_C] = 1'b1;
            3'd7: flags_n[F_C] = ~flags[F_C];
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // memory port
  always_comb begin
    unique case (cmd.mem_sel)
      MA_PC:    maddr16 = pc;
      MA_PC1:   maddr16 = pc + 16'd1;
      MA_PC2:   maddr16 = pc + 16'd2;
      MA_DATA:  maddr16 = daddr;
      MA_DATA1: maddr16 = daddr + 16'd1;
      default:  maddr16 = item_addr;
    endcase
    unique case (cmd.wr_sel)
      WD_EXEC: wdata = wdata_x;
      WD_HIGH: wdata = rh;
      default: wdata = item_data;
    endcase
  end
  assign maddr = maddr16[ADDR_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[maddr] <= wdata;
    if (cmd.mem_rd) mem_q <= mem[maddr];
  end

  // item and fetch registers
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_addr <= in_address;
      item_data <= in_data;
    end
    if (cmd.cap_op) op <= mem_q;
    if (cmd.cap_b1) b1 <= mem_q;
    if (cmd.cap_b2) b2 <= mem_q;
    if (cmd.cap_t1) t1 <= mem_q;
    if (cmd.cap_t2) t2 <= mem_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0; sp <= '0;
      ra <= '0; rb <= '0; rc <= '0; rd <= '0; re <= '0; rh <= '0; rl <= '0;
      flags <= '0; rbyte <= '0; flt <= 1'b0;
    end else begin
      if (cmd.latch_item) begin
        rbyte <= '0;
        flt   <= 1'b0;
      end
      if (cmd.cap_rd)    rbyte <= mem_q;
      if (cmd.set_fault) flt <= 1'b1;
      if (cmd.set_pc)    pc <= item_addr;
      if (cmd.exec) begin
        pc    <= pc + {14'd0, st.len};
        flags <= flags_n;
        if (rw_en) begin
          unique case (rw_code)
            RC_B: rb <= rw_val;
            RC_C: rc <= rw_val;
            RC_D: rd <= rw_val;
            RC_E: re <= rw_val;
            RC_H: rh <= rw_val;
            RC_L: rl <= rw_val;
            RC_A: ra <= rw_val;
            default: ;
          endcase
        end
        if (pw_en) begin
          unique case (pw_code)
            RP_BC: begin rb <= pw_val[15:8]; rc <= pw_val[7:0]; end
            RP_DE: begin rd <= pw_val[15:8]; re <= pw_val[7:0]; end
            RP_HL: begin rh <= pw_val[15:8]; rl <= pw_val[7:0]; end
            default: sp <= pw_val;
          endcase
        end
      end
    end
  end

  // output register: snapshot of the state after the item
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pc    <= cmd.set_pc ? item_addr : (cmd.exec ? pc + {14'd0, st.len} : pc);
      out_sp    <= (cmd.exec && pw_en && pw_code == RP_SP) ? pw_val : sp;
      out_a     <= (cmd.exec && rw_en && rw_code == RC_A) ? rw_val : ra;
      out_b     <= (cmd.exec && rw_en && rw_code == RC_B) ? rw_val :
                   (cmd.exec && pw_en && pw_code == RP_BC) ? pw_val[15:8] : rb;
      out_c     <= (cmd.exec && rw_en && rw_code == RC_C) ? rw_val :
                   (cmd.exec && pw_en && pw_code == RP_BC) ? pw_val[7:0] : rc;
      out_d     <= (cmd.exec && rw_en && rw_code == RC_D) ? rw_val :
                   (cmd.exec && pw_en && pw_code == RP_DE) ? pw_val[15:8] : rd;
      out_e     <= (cmd.exec && rw_en && rw_code == RC_E) ? rw_val :
                   (cmd.exec && pw_en && pw_code == RP_DE) ? pw_val[7:0] : re;
      out_h     <= (cmd.exec && rw_en && rw_code == RC_H) ? rw_val :
                   (cmd.exec && pw_en && pw_code == RP_HL) ? pw_val[15:8] : rh;
      out_l     <= (cmd.exec && rw_en && rw_code == RC_L) ? rw_val :
                   (cmd.exec && pw_en && pw_code == RP_HL) ? pw_val[7:0] : rl;
      out_flags <= cmd.exec ? flags_n : flags;
      read_byte <= cmd.cap_rd ? mem_q : rbyte;
      fault     <= cmd.set_fault | flt;
    end
  end

endmodule
`default_nettype wire

// File: tb/cpu8080_subset_execute_test.sv
`default_nettype none
module cpu8080_subset_execute_test;
  import cse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Opcode groups by the low three bits, below 0x40
  localparam logic [2:0] G_NOP  = 3'd0;
  localparam logic [2:0] G_LXI  = 3'd1;   // LXI, or DAD when bit 3 set
  localparam logic [2:0] G_LDST = 3'd2;
  localparam logic [2:0] G_INX  = 3'd3;   // INX, or DCX when bit 3 set
  localparam logic [2:0] G_INR  = 3'd4;
  localparam logic [2:0] G_DCR  = 3'd5;
  localparam logic [2:0] G_MVI  = 3'd6;
  localparam logic [2:0] G_ROT  = 3'd7;

  // Accumulator and carry operations within group seven
  localparam logic [2:0] R_RLC = 3'd0;
  localparam logic [2:0] R_RRC = 3'd1;
  localparam logic [2:0] R_RAL = 3'd2;
  localparam logic [2:0] R_RAR = 3'd3;
  localparam logic [2:0] R_CMA = 3'd5;
  localparam logic [2:0] R_STC = 3'd6;
  localparam logic [2:0] R_CMC = 3'd7;

  localparam logic [7:0] OP_NOP    = 8'h00;
  localparam logic [7:0] OP_LXI_B  = 8'h01;
  localparam logic [7:0] OP_STAX_B = 8'h02;
  localparam logic [7:0] OP_INX_B  = 8'h03;
  localparam logic [7:0] OP_DAD_B  = 8'h09;
  localparam logic [7:0] OP_LDAX_B = 8'h0a;
  localparam logic [7:0] OP_DCX_B  = 8'h0b;
  localparam logic [7:0] OP_STAX_D = 8'h12;
  localparam logic [7:0] OP_LDAX_D = 8'h1a;
  localparam logic [7:0] OP_LXI_H  = 8'h21;
  localparam logic [7:0] OP_LXI_SP = 8'h31;
  localparam logic [7:0] OP_STA    = 8'h32;
  localparam logic [7:0] OP_INX_SP = 8'h33;
  localparam logic [7:0] OP_INR_M  = 8'h34;
  localparam logic [7:0] OP_DCR_M  = 8'h35;
  localparam logic [7:0] OP_MVI_M  = 8'h36;
  localparam logic [7:0] OP_STC    = 8'h37;
  localparam logic [7:0] OP_DAD_SP = 8'h39;
  localparam logic [7:0] OP_LDA    = 8'h3a;
  localparam logic [7:0] OP_DCX_SP = 8'h3b;
  localparam logic [7:0] OP_INR_A  = 8'h3c;
  localparam logic [7:0] OP_DCR_A  = 8'h3d;
  localparam logic [7:0] OP_MVI_A  = 8'h3e;
  localparam logic [7:0] OP_CMC    = 8'h3f;
  localparam logic [7:0] OP_RLC    = 8'h07;
  localparam logic [7:0] OP_RRC    = 8'h0f;
  localparam logic [7:0] OP_RAL    = 8'h17;
  localparam logic [7:0] OP_RAR    = 8'h1f;
  localparam logic [7:0] OP_CMA    = 8'h2f;
  localparam logic [7:0] OP_MOV_MA = 8'h77;
  localparam logic [7:0] OP_MOV_AM = 8'h7e;
  localparam logic [7:0] OP_LAST_IMPL = 8'h7f;
  localparam logic [7:0] OP_FIRST_BAD = 8'h80;
  localparam logic [7:0] OP_ALL_ONES  = 8'hff;

  localparam logic [16:0] AMASK = (17'd1 << ADDR_WIDTH) - 17'd1;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS = 1500;

  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] sp;
    logic [7:0]  a, b, c, d, e, h, l;
    logic [3:0]  flags;
    logic [7:0]  rd_byte;
    logic        fault;
  } cpu_snap_t;

  logic clk;
  logic rst;
  cse_in_if  req ();
  cse_out_if rsp ();

  cpu8080_subset_execute u_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // Shadow machine state, advanced as each beat is sent
  logic [7:0]  mem_shadow [0:65535];
  bit          mem_known  [0:65535];
  logic [15:0] pc_s, sp_s;
  logic [7:0]  rg [0:7];        // indexed by register code; RC_M unused
  logic [3:0]  flags_s;

  cpu_snap_t   results_due [$];
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned items_sent;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------
  function automatic logic [15:0] phys(input logic [15:0] addr);
    return 16'(({1'b0, addr}) & AMASK);
  endfunction

  function automatic logic [7:0] shadow_rd(input logic [15:0] addr);
    return mem_shadow[phys(addr)];
  endfunction

  function automatic void shadow_wr(input logic [15:0] addr, input logic [7:0] v);
    mem_shadow[phys(addr)] = v;
    mem_known[phys(addr)]  = 1'b1;
  endfunction

  function automatic logic [15:0] hl_val();
    return {rg[RC_H], rg[RC_L]};
  endfunction

  function automatic logic [7:0] reg_get(input logic [2:0] code);
    if (code == RC_M) return shadow_rd(hl_val());
    return rg[code];
  endfunction

  function automatic void reg_put(input logic [2:0] code, input logic [7:0] v);
    if (code == RC_M) shadow_wr(hl_val(), v);
    else rg[code] = v;
  endfunction

  // BC -> B,C; DE -> D,E; HL -> H,L: high register code is twice the pair code
  function automatic logic [15:0] pair_get(input logic [1:0] rp);
    if (rp == RP_SP) return sp_s;
    return {rg[{rp, 1'b0}], rg[{rp, 1'b1}]};
  endfunction

  function automatic void pair_put(input logic [1:0] rp, input logic [15:0] v);
    if (rp == RP_SP) sp_s = v;
    else begin
      rg[{rp, 1'b0}] = v[15:8];
      rg[{rp, 1'b1}] = v[7:0];
    end
  endfunction

  function automatic void szp_update(input logic [7:0] v);
    flags_s[F_S] = v[7];
    flags_s[F_Z] = (v == 8'd0);
    flags_s[F_P] = ~^v;
  endfunction

  function automatic bit is_unimpl(input logic [7:0] op);
    return op >= OP_FIRST_BAD || op == OP_DAA || op == OP_HLT;
  endfunction

  function automatic int instr_len(input logic [7:0] op);
    if (is_unimpl(op) || op >= 8'h40) return 1;
    case (op[2:0])
      G_LXI:   return op[3] ? 1 : 3;
      G_LDST:  return op[5] ? 3 : 1;
      G_MVI:   return 2;
      default: return 1;
    endcase
  endfunction

  // One instruction at the shadow pc; returns the fault bit
  function automatic logic exec_shadow();
    logic [15:0] pcv;
    logic [7:0]  op, b1, b2, av, v;
    logic [15:0] imm;
    logic [16:0] sum;
    logic [1:0]  rp;
    logic [2:0]  dst;
    pcv = pc_s;
    op  = shadow_rd(pcv);
    b1  = shadow_rd(pcv + 16'd1);
    b2  = shadow_rd(pcv + 16'd2);
    imm = {b2, b1};
    rp  = op[5:4];
    dst = op[5:3];
    av  = rg[RC_A];
    if (is_unimpl(op)) return 1'b1;
    if (op >= 8'h40) begin
      reg_put(dst, reg_get(op[2:0]));
    end else begin
      case (op[2:0])
        G_NOP: ;
        G_LXI: begin
          if (op[3]) begin
            sum = {1'b0, hl_val()} + {1'b0, pair_get(rp)};
            pair_put(RP_HL, sum[15:0]);
            flags_s[F_C] = sum[16];
          end else begin
            pair_put(rp, imm);
          end
        end
        G_LDST: begin
          case (op)
            OP_STAX_B, OP_STAX_D: shadow_wr(pair_get(rp), rg[RC_A]);
            OP_LDAX_B, OP_LDAX_D: rg[RC_A] = shadow_rd(pair_get(rp));
            OP_SHLD: begin
              shadow_wr(imm, rg[RC_L]);
              shadow_wr(imm + 16'd1, rg[RC_H]);
            end
            OP_LHLD: begin
              rg[RC_L] = shadow_rd(imm);
              rg[RC_H] = shadow_rd(imm + 16'd1);
            end
            OP_STA:  shadow_wr(imm, rg[RC_A]);
            default: rg[RC_A] = shadow_rd(imm);
          endcase
        end
        G_INX: pair_put(rp, op[3] ? pair_get(rp) - 16'd1 : pair_get(rp) + 16'd1);
        G_INR: begin
          v = reg_get(dst) + 8'd1;
          reg_put(dst, v);
          szp_update(v);
        end
        G_DCR: begin
          v = reg_get(dst) - 8'd1;
          reg_put(dst, v);
          szp_update(v);
        end
        G_MVI: reg_put(dst, b1);
        default: begin
          case (dst)
            R_RLC: begin rg[RC_A] = {av[6:0], av[7]};        flags_s[F_C] = av[7]; end
            R_RRC: begin rg[RC_A] = {av[0], av[7:1]};        flags_s[F_C] = av[0]; end
            R_RAL: begin rg[RC_A] = {av[6:0], flags_s[F_C]}; flags_s[F_C] = av[7]; end
            R_RAR: begin rg[RC_A] = {flags_s[F_C], av[7:1]}; flags_s[F_C] = av[0]; end
            R_CMA: rg[RC_A] = ~av;
            R_STC: flags_s[F_C] = 1'b1;
            default: flags_s[F_C] = ~flags_s[F_C];
          endcase
        end
      endcase
    end
    pc_s = pcv + 16'(instr_len(op));
    return 1'b0;
  endfunction

  function automatic void shadow_step(input logic [1:0] kind, input logic [15:0] addr,
                                      input logic [7:0] data);
    cpu_snap_t s;
    s = '0;
    case (kind)
      KIND_WRITE: shadow_wr(addr, data);
      KIND_EXEC:  s.fault = exec_shadow();
      KIND_READ:  s.rd_byte = shadow_rd(addr);
      default:    pc_s = addr;
    endcase
    s.pc = pc_s;  s.sp = sp_s;
    s.a = rg[RC_A]; s.b = rg[RC_B]; s.c = rg[RC_C]; s.d = rg[RC_D];
    s.e = rg[RC_E]; s.h = rg[RC_H]; s.l = rg[RC_L];
    s.flags = flags_s;
    results_due.push_back(s);
  endfunction

  // ---------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------
  task automatic send_item(input logic [1:0] kind, input logic [15:0] addr,
                           input logic [7:0] data);
    shadow_step(kind, addr, data);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.kind    <= kind;
    req.address <= addr;
    req.data    <= data;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic poke_byte(input logic [15:0] addr, input logic [7:0] v);
    send_item(KIND_WRITE, addr, v);
  endtask

  task automatic peek_byte(input logic [15:0] addr);
    send_item(KIND_READ, addr, 8'd0);
  endtask

  task automatic jump_to(input logic [15:0] addr);
    send_item(KIND_SETPC, addr, 8'd0);
  endtask

  // Give a never-written byte a value so nothing reads undefined memory
  task automatic fill_if_unknown(input logic [15:0] addr);
    if (!mem_known[phys(addr)]) poke_byte(addr, 8'($urandom));
  endtask

  // Lay the instruction down at pc, seed whatever it will read, then run it
  task automatic run_instr(input logic [7:0] op, input logic [7:0] b1, input logic [7:0] b2);
    int n;
    logic [15:0] imm;
    n   = instr_len(op);
    imm = {b2, b1};
    poke_byte(pc_s, op);
    if (n > 1) poke_byte(pc_s + 16'd1, b1);
    if (n > 2) poke_byte(pc_s + 16'd2, b2);
    if (!is_unimpl(op)) begin
      if (op >= 8'h40 && op[2:0] == RC_M) fill_if_unknown(hl_val());
      if (op < 8'h40 && (op[2:0] == G_INR || op[2:0] == G_DCR) && op[5:3] == RC_M)
        fill_if_unknown(hl_val());
      case (op)
        OP_LDAX_B, OP_LDAX_D: fill_if_unknown(pair_get(op[5:4]));
        OP_LHLD: begin
          fill_if_unknown(imm);
          fill_if_unknown(imm + 16'd1);
        end
        OP_LDA: fill_if_unknown(imm);
        default: ;
      endcase
    end
    send_item(KIND_EXEC, 16'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------
  // Response side: random back-pressure and field checks
  // ---------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] expv,
                             input logic [15:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %h, got %h", name, expv, actv);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    cpu_snap_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (results_due.size() == 0) begin
        $error("result beat with nothing outstanding");
        error_count++;
      end else begin
        e = results_due.pop_front();
        check_field("out_pc",    e.pc,              rsp.out_pc);
        check_field("out_sp",    e.sp,              rsp.out_sp);
        check_field("out_a",     16'(e.a),          16'(rsp.out_a));
        check_field("out_b",     16'(e.b),          16'(rsp.out_b));
        check_field("out_c",     16'(e.c),          16'(rsp.out_c));
        check_field("out_d",     16'(e.d),          16'(rsp.out_d));
        check_field("out_e",     16'(e.e),          16'(rsp.out_e));
        check_field("out_h",     16'(e.h),          16'(rsp.out_h));
        check_field("out_l",     16'(e.l),          16'(rsp.out_l));
        check_field("out_flags", 16'(e.flags),      16'(rsp.out_flags));
        check_field("read_byte", 16'(e.rd_byte),    16'(rsp.read_byte));
        check_field("fault",     16'(e.fault),      16'(rsp.fault));
      end
    end
    rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------

  // LXI and MVI at both extremes, into SP, BC, HL, A and M
  task automatic test_loads();
    run_instr(OP_LXI_SP, 8'hff, 8'hff);
    run_instr(OP_LXI_B,  8'h00, 8'h00);
    run_instr(OP_LXI_H,  8'h34, 8'h12);
    run_instr(OP_MVI_M,  8'hff, 8'h00);
    run_instr(OP_MVI_A,  8'h80, 8'h00);
    peek_byte(16'h1234);
  endtask

  // Stores and loads through pairs and direct addresses; SHLD/LHLD across the top
  task automatic test_memory_ops();
    run_instr(OP_STAX_B, 8'h00, 8'h00);
    run_instr(OP_LDAX_D, 8'h00, 8'h00);
    run_instr(OP_SHLD,   8'hff, 8'hff);
    run_instr(OP_LHLD,   8'hff, 8'hff);
    run_instr(OP_STA,    8'h00, 8'h80);
    run_instr(OP_LDA,    8'hff, 8'hff);
    run_instr(OP_MOV_AM, 8'h00, 8'h00);
    peek_byte(16'hffff);
  endtask

  // Wrap-around of INR/DCR/INX/DCX, DAD carry, flag cases
  task automatic test_arith();
    run_instr(OP_INX_SP, 8'h00, 8'h00);   // ffff -> 0000
    run_instr(OP_DCX_SP, 8'h00, 8'h00);   // 0000 -> ffff
    run_instr(OP_DAD_SP, 8'h00, 8'h00);   // carry out of HL
    run_instr(OP_MVI_A,  8'hff, 8'h00);
    run_instr(OP_INR_A,  8'h00, 8'h00);   // zero result
    run_instr(OP_DCR_A,  8'h00, 8'h00);   // ff, sign
    run_instr(OP_INR_M,  8'h00, 8'h00);
    run_instr(OP_DCR_M,  8'h00, 8'h00);
  endtask

  task automatic test_rotates();
    run_instr(OP_RLC, 8'h00, 8'h00);
    run_instr(OP_RRC, 8'h00, 8'h00);
    run_instr(OP_RAL, 8'h00, 8'h00);
    run_instr(OP_RAR, 8'h00, 8'h00);
    run_instr(OP_CMA, 8'h00, 8'h00);
    run_instr(OP_STC, 8'h00, 8'h00);
    run_instr(OP_CMC, 8'h00, 8'h00);
  endtask

  // DAA, HLT and the upper half must fault and change nothing; 7f, just below, must not
  task automatic test_faults();
    run_instr(OP_DAA, 8'h00, 8'h00);
    run_instr(OP_HLT, 8'h00, 8'h00);
    run_instr(OP_FIRST_BAD, 8'h00, 8'h00);
    run_instr(OP_ALL_ONES, 8'h00, 8'h00);
    run_instr(OP_LAST_IMPL, 8'h00, 8'h00);
  endtask

  // Three-byte instruction straddling the end of memory; pc wraps
  task automatic test_pc_wrap();
    jump_to(16'hfffe);
    run_instr(OP_LXI_B, 8'haa, 8'h55);
    jump_to(16'hffff);
    run_instr(OP_NOP, 8'h00, 8'h00);
  endtask

  task automatic random_item();
    int unsigned pick;
    logic [7:0]  op;
    pick = $urandom_range(99);
    if (pick < 70) begin
      if ($urandom_range(19) == 0) op = 8'($urandom_range(255, 128));
      else op = 8'($urandom_range(127));
      run_instr(op, 8'($urandom), 8'($urandom));
    end else if (pick < 80) begin
      poke_byte(16'($urandom), 8'($urandom));
    end else if (pick < 90) begin
      op = 8'($urandom);
      fill_if_unknown({op, op ^ 8'h5a});
      peek_byte({op, op ^ 8'h5a});
    end else if (pick < 95) begin
      fill_if_unknown(pc_s);        // pc may sit on a fresh byte after a jump
      peek_byte(pc_s);
    end else begin
      jump_to(16'($urandom));
    end
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned stop_at;
    bit paused;
    stop_at = items_sent + n_items;
    paused  = 1'b0;
    while (items_sent < stop_at) begin
      random_item();
      // hold off once until everything has drained
      if (!paused && items_sent > stop_at - n_items / 2) begin
        paused = 1'b1;
        req.valid <= 1'b0;
        wait_drained();
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.kind      <= KIND_WRITE;
    req.address   <= 16'd0;
    req.data      <= 8'd0;
    items_sent     = 0;
    pc_s = 16'd0; sp_s = 16'd0; flags_s = 4'd0;
    for (int i = 0; i < 8; i++) rg[i] = 8'd0;
    send_idle_pct = 23;
    recv_idle_pct = 77;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_loads();
    test_memory_ops();
    test_arith();
    test_rotates();
    test_faults();
    test_pc_wrap();

    test_random(RANDOM_ITEMS / 3);
    send_idle_pct = 77;
    recv_idle_pct = 23;
    test_random(RANDOM_ITEMS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(RANDOM_ITEMS / 3);

    req.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
